// ----- hw/rtl/alfd_pkg.sv -----
// alfd_pkg: shared types and constants of the addressed length frame deframer
// no dependencies

package alfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // largest payload length accepted in a header
  localparam logic [LenW-1:0] MaxPayload = 16'd256;

  localparam logic [TickW-1:0] TimeoutReset = 16'd100;
  localparam logic [ByteW-1:0] AddressReset = 8'd0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOwnAddress  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks = 1'd1;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEnd     = 2'd1,
    KindTimeout = 2'd2,
    KindTooLong = 2'd3
  } kind_e;

  // request type of an input beat
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

endpackage

// ----- hw/rtl/alfd_if.sv -----
// alfd_in_if / alfd_out_if: valid-ready channels of the deframer
// depends on alfd_pkg for field widths

interface alfd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [alfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface alfd_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [alfd_pkg::ByteW-1:0] command;
  logic [alfd_pkg::ByteW-1:0] data_byte;
  logic [alfd_pkg::ByteW-1:0] byte_index;
  logic [alfd_pkg::LenW-1:0]  frame_length;
  logic [alfd_pkg::CrcW-1:0]  received_crc;
  logic                       last;

  modport source (output valid, output kind, output command, output data_byte,
                  output byte_index, output frame_length, output received_crc,
                  output last, input ready);
  modport sink   (input valid, input kind, input command, input data_byte,
                  input byte_index, input frame_length, input received_crc,
                  input last, output ready);
endinterface

// ----- hw/rtl/addressed_length_frame_deframer.sv -----
// addressed_length_frame_deframer: parses address/command/length/payload/crc frames
// depends on alfd_pkg and the channel interfaces in alfd_if.sv
//
//   channel   dir   handshake      beat
//   in_i      in    valid/ready    req_type, rx_byte (byte or timer tick)
//   out_o     out   valid/ready    kind, command, data_byte, byte_index,
//                                  frame_length, received_crc, last
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_data_i
//
// one input beat per cycle while in_i.ready is high; the parser state updates in
// the accept cycle and any result appears in the output register on the next cycle
// in_i.ready is low only while a result is held and out_o.ready is low
// reset idles the parser and returns control and config registers to reset values

module addressed_length_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  alfd_in_if.sink                       in_i,
  alfd_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [alfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [alfd_pkg::CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    PhIdle, PhCmd, PhLen0, PhLen1, PhData, PhCrc0, PhCrc1
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [alfd_pkg::ByteW-1:0]  own_addr_q;
  logic [alfd_pkg::TickW-1:0]  timeout_q;
  logic [alfd_pkg::ByteW-1:0]  cmd_q, cmd_d;
  logic [alfd_pkg::LenW-1:0]   len_q, len_d;
  logic [alfd_pkg::LenW-1:0]   count_q, count_d;
  logic [alfd_pkg::ByteW-1:0]  crc_lo_q, crc_lo_d;
  logic [alfd_pkg::TickW-1:0]  ticks_q, ticks_d;

  logic                        out_valid_q;
  alfd_pkg::kind_e             kind_q, kind_d;
  logic [alfd_pkg::ByteW-1:0]  o_cmd_q, o_data_q, o_idx_q;
  logic [alfd_pkg::ByteW-1:0]  o_data_d, o_idx_d;
  logic [alfd_pkg::LenW-1:0]   o_len_q;
  logic [alfd_pkg::CrcW-1:0]   o_crc_q, o_crc_d;
  logic                        o_last_q, o_last_d;

  logic                        accept;
  logic                        emit;
  logic [alfd_pkg::TickW-1:0]  limit;
  logic [alfd_pkg::TickW-1:0]  ticks_inc;
  logic [alfd_pkg::LenW-1:0]   count_inc;
  logic [alfd_pkg::LenW-1:0]   len_full;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // a zero timeout behaves as one
  assign limit     = (timeout_q == '0) ? {{(alfd_pkg::TickW-1){1'b0}}, 1'b1} : timeout_q;
  assign ticks_inc = ticks_q + {{(alfd_pkg::TickW-1){1'b0}}, 1'b1};
  assign count_inc = count_q + {{(alfd_pkg::LenW-1){1'b0}}, 1'b1};
  assign len_full  = {in_i.rx_byte, len_q[alfd_pkg::ByteW-1:0]};

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    count_d  = count_q;
    crc_lo_d = crc_lo_q;
    ticks_d  = ticks_q;
    emit     = 1'b0;
    kind_d   = alfd_pkg::KindPayload;
    o_data_d = '0;
    o_idx_d  = '0;
    o_crc_d  = '0;
    o_last_d = 1'b0;

    if (in_i.req_type == alfd_pkg::ReqTick) begin
      if (phase_q == PhIdle) begin
        ticks_d = '0;
      end else if (ticks_inc >= limit) begin
        phase_d  = PhIdle;
        ticks_d  = '0;
        emit     = 1'b1;
        kind_d   = alfd_pkg::KindTimeout;
        o_last_d = 1'b1;
      end else begin
        ticks_d = ticks_inc;
      end
    end else begin
      ticks_d = '0;
      unique case (phase_q)
        PhIdle: begin
          if (in_i.rx_byte == own_addr_q) begin
            cmd_d    = '0;
            len_d    = '0;
            count_d  = '0;
            crc_lo_d = '0;
            phase_d  = PhCmd;
          end
        end
        PhCmd: begin
          cmd_d   = in_i.rx_byte;
          phase_d = PhLen0;
        end
        PhLen0: begin
          len_d   = {{(alfd_pkg::LenW-alfd_pkg::ByteW){1'b0}}, in_i.rx_byte};
          phase_d = PhLen1;
        end
        PhLen1: begin
          len_d   = len_full;
          count_d = '0;
          if (len_full > alfd_pkg::MaxPayload) begin
            phase_d  = PhIdle;
            emit     = 1'b1;
            kind_d   = alfd_pkg::KindTooLong;
            o_last_d = 1'b1;
          end else if (len_full == '0) begin
            phase_d = PhCrc0;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          count_d  = count_inc;
          if (count_inc >= len_q) phase_d = PhCrc0;
          emit     = 1'b1;
          kind_d   = alfd_pkg::KindPayload;
          o_data_d = in_i.rx_byte;
          o_idx_d  = count_q[alfd_pkg::ByteW-1:0];
        end
        PhCrc0: begin
          crc_lo_d = in_i.rx_byte;
          phase_d  = PhCrc1;
        end
        PhCrc1: begin
          phase_d  = PhIdle;
          emit     = 1'b1;
          kind_d   = alfd_pkg::KindEnd;
          o_crc_d  = {in_i.rx_byte, crc_lo_q};
          o_last_d = 1'b1;
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cmd_q       <= '0;
      len_q       <= '0;
      count_q     <= '0;
      crc_lo_q    <= '0;
      ticks_q     <= '0;
      own_addr_q  <= alfd_pkg::AddressReset;
      timeout_q   <= alfd_pkg::TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          alfd_pkg::CfgOwnAddress:   own_addr_q <= cfg_data_i[alfd_pkg::ByteW-1:0];
          alfd_pkg::CfgTimeoutTicks: timeout_q  <= cfg_data_i[alfd_pkg::TickW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q  <= phase_d;
        cmd_q    <= cmd_d;
        len_q    <= len_d;
        count_q  <= count_d;
        crc_lo_q <= crc_lo_d;
        ticks_q  <= ticks_d;
      end
      // output slot is free whenever a beat is accepted
      if (accept) out_valid_q <= emit;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only with a beat that makes a result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q   <= kind_d;
      o_cmd_q  <= cmd_d;
      o_data_q <= o_data_d;
      o_idx_q  <= o_idx_d;
      o_len_q  <= len_d;
      o_crc_q  <= o_crc_d;
      o_last_q <= o_last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.command      = o_cmd_q;
  assign out_o.data_byte    = o_data_q;
  assign out_o.byte_index   = o_idx_q;
  assign out_o.frame_length = o_len_q;
  assign out_o.received_crc = o_crc_q;
  assign out_o.last         = o_last_q;

endmodule

// ----- sim/tb_alfd_frame_check.sv -----
`timescale 1ns / 1ps
// tb_alfd_frame_check: watches the deframer channels, predicts every result beat
// and compares it field by field; depends on alfd_pkg

module tb_alfd_frame_check
  import alfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                in_req_type_i,
  input  logic [ByteW-1:0]    in_rx_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          out_kind_i,
  input  logic [ByteW-1:0]    out_command_i,
  input  logic [ByteW-1:0]    out_data_byte_i,
  input  logic [ByteW-1:0]    out_byte_index_i,
  input  logic [LenW-1:0]     out_frame_length_i,
  input  logic [CrcW-1:0]     out_received_crc_i,
  input  logic                out_last_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef enum logic [2:0] {
    ParseIdle, ParseCmd, ParseLen0, ParseLen1, ParseData, ParseCrc0, ParseCrc1
  } parse_phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic [LenW-1:0]  frame_length;
    logic [CrcW-1:0]  received_crc;
    logic             last;
  } frame_result_t;

  frame_result_t    expected_results[$];

  logic [ByteW-1:0] own_addr_q;
  logic [TickW-1:0] timeout_q;
  parse_phase_e     phase_q;
  logic [ByteW-1:0] cmd_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  count_q;
  logic [ByteW-1:0] crc_low_q;
  logic [TickW-1:0] ticks_q;

  task automatic report_mismatch(input string msg);
    // keep the log short on a badly broken block
    if (fail_count_o < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic frame_result_t make_result(input kind_e kind,
                                                input logic [ByteW-1:0] data,
                                                input logic [ByteW-1:0] index,
                                                input logic [CrcW-1:0] crc);
    frame_result_t r;
    r.kind         = kind;
    r.command      = cmd_q;
    r.data_byte    = data;
    r.byte_index   = index;
    r.frame_length = len_q;
    r.received_crc = crc;
    r.last         = (kind != KindPayload);
    return r;
  endfunction

  task automatic advance_parser(input logic req, input logic [ByteW-1:0] b);
    logic [TickW-1:0] limit;
    logic [ByteW-1:0] index;
    if (req == ReqTick) begin
      if (phase_q == ParseIdle) begin
        ticks_q = '0;
      end else begin
        limit   = (timeout_q == '0) ? 16'd1 : timeout_q;
        ticks_q = ticks_q + 16'd1;
        if (ticks_q >= limit) begin
          phase_q = ParseIdle;
          ticks_q = '0;
          expected_results.push_back(make_result(KindTimeout, '0, '0, '0));
        end
      end
    end else begin
      ticks_q = '0;
      case (phase_q)
        ParseIdle: begin
          if (b == own_addr_q) begin
            cmd_q     = '0;
            len_q     = '0;
            count_q   = '0;
            crc_low_q = '0;
            phase_q   = ParseCmd;
          end
        end
        ParseCmd: begin
          cmd_q   = b;
          phase_q = ParseLen0;
        end
        ParseLen0: begin
          len_q   = {8'd0, b};
          phase_q = ParseLen1;
        end
        ParseLen1: begin
          len_q   = {b, len_q[7:0]};
          count_q = '0;
          if (len_q > MaxPayload) begin
            phase_q = ParseIdle;
            expected_results.push_back(make_result(KindTooLong, '0, '0, '0));
          end else begin
            // an empty payload skips straight to the crc bytes
            phase_q = (len_q == '0) ? ParseCrc0 : ParseData;
          end
        end
        ParseData: begin
          index   = count_q[7:0];
          count_q = count_q + 16'd1;
          if (count_q >= len_q) phase_q = ParseCrc0;
          expected_results.push_back(make_result(KindPayload, b, index, '0));
        end
        ParseCrc0: begin
          crc_low_q = b;
          phase_q   = ParseCrc1;
        end
        ParseCrc1: begin
          phase_q = ParseIdle;
          expected_results.push_back(make_result(KindEnd, '0, '0, {b, crc_low_q}));
        end
        default: phase_q = ParseIdle;
      endcase
    end
  endtask

  task automatic compare_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 16'(out_kind_i), 16'(want.kind));
      check_field("command", 16'(out_command_i), 16'(want.command));
      check_field("data_byte", 16'(out_data_byte_i), 16'(want.data_byte));
      check_field("byte_index", 16'(out_byte_index_i), 16'(want.byte_index));
      check_field("frame_length", out_frame_length_i, want.frame_length);
      check_field("received_crc", out_received_crc_i, want.received_crc);
      check_field("last", 16'(out_last_i), 16'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   = AddressReset;
      timeout_q    = TimeoutReset;
      phase_q      = ParseIdle;
      cmd_q        = '0;
      len_q        = '0;
      count_q      = '0;
      crc_low_q    = '0;
      ticks_q      = '0;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      // pop before push: a beat accepted now cannot have its result out yet
      if (out_valid_i && out_ready_i) compare_result();
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgOwnAddress) own_addr_q = cfg_data_i[ByteW-1:0];
        else if (cfg_idx_i == CfgTimeoutTicks) timeout_q = cfg_data_i[TickW-1:0];
      end
      if (in_valid_i && in_ready_i) advance_parser(in_req_type_i, in_rx_byte_i);
    end
    pending_o = expected_results.size();
  end

endmodule

// ----- sim/tb_addressed_length_frame_deframer.sv -----
`timescale 1ns / 1ps
// tb_addressed_length_frame_deframer: drives bytes, ticks and register writes into
// the deframer; depends on alfd_pkg, alfd_if.sv and tb_alfd_frame_check

module tb_addressed_length_frame_deframer;
  import alfd_pkg::*;

  localparam int FullFrame = 1 << 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  alfd_in_if  in_ch ();
  alfd_out_if out_ch ();

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int unsigned beats_sent = 0;
  logic [ByteW-1:0] cur_addr;
  int          cur_limit;

  always #2 clk_i = ~clk_i;

  addressed_length_frame_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tb_alfd_frame_check u_frame_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .in_req_type_i      (in_ch.req_type),
    .in_rx_byte_i       (in_ch.rx_byte),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_kind_i         (out_ch.kind),
    .out_command_i      (out_ch.command),
    .out_data_byte_i    (out_ch.data_byte),
    .out_byte_index_i   (out_ch.byte_index),
    .out_frame_length_i (out_ch.frame_length),
    .out_received_crc_i (out_ch.received_crc),
    .out_last_i         (out_ch.last),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // result side stalls at random, except during the calm stretch
  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 36);
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_beat(input logic req, input logic [ByteW-1:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.rx_byte  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  // hold off the sender until every predicted result beat has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ByteW-1:0] addr, input logic [TickW-1:0] tmo);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgOwnAddress;
    cfg_data <= CfgDataW'(addr);
    @(posedge clk_i);
    cfg_idx  <= CfgTimeoutTicks;
    cfg_data <= tmo;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    cur_addr  = addr;
    cur_limit = (tmo == '0) ? 1 : int'(tmo);
  endtask

  // sends the first cut bytes of a frame, with a few ticks between bytes now and then
  task automatic send_frame(input logic [ByteW-1:0] cmd, input logic [LenW-1:0] len,
                            input int cut);
    int total;
    int n;
    logic [ByteW-1:0] b;
    total = 4 + ((len <= MaxPayload) ? int'(len) + 2 : 0);
    for (int i = 0; i < total && i < cut; i++) begin
      if (i == 0) b = cur_addr;
      else if (i == 1) b = cmd;
      else if (i == 2) b = len[7:0];
      else if (i == 3) b = len[15:8];
      else b = 8'($urandom_range(255));
      if (i > 0 && $urandom_range(99) < 10) begin
        // stay under the limit, but at a limit of one a lone tick aborts
        if (cur_limit > 1) n = $urandom_range(1, (cur_limit > 4) ? 4 : cur_limit - 1);
        else n = ($urandom_range(9) == 0) ? 1 : 0;
        repeat (n) send_beat(ReqTick, 8'($urandom_range(255)));
      end
      send_beat(ReqByte, b);
    end
  endtask

  task automatic random_frame();
    int r;
    int s;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] b;
    r = $urandom_range(99);
    s = $urandom_range(99);
    if (s == 0) len = $urandom_range(1) ? MaxPayload : LenW'($urandom_range(200, 255));
    else if (s < 15) len = '0;
    else len = LenW'($urandom_range(1, 8));
    if (r < 72) begin
      send_frame(8'($urandom_range(255)), len, FullFrame);
    end else if (r < 80) begin
      send_frame(8'($urandom_range(255)),
                 $urandom_range(1) ? 16'hFFFF : LenW'($urandom_range(257, 65534)), FullFrame);
    end else if (r < 88) begin
      // cut frame, then enough ticks to hit the timeout where that is affordable
      send_frame(8'($urandom_range(255)), len, $urandom_range(1, int'(len) + 5));
      if (cur_limit <= 16 || (cur_limit <= 100 && $urandom_range(3) == 0))
        repeat (cur_limit) send_beat(ReqTick, 8'($urandom_range(255)));
    end else if (r < 95) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(255));
        if (b == cur_addr) b = ~b;
        send_beat(ReqByte, b);
      end
    end else begin
      repeat ($urandom_range(1, 3)) send_beat(ReqTick, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [ByteW-1:0] addr_sel;
    logic [TickW-1:0] tmo_sel;
    int unsigned      phase_start;
    int               frames;
    in_ch.valid    = 1'b0;
    in_ch.req_type = ReqByte;
    in_ch.rx_byte  = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgOwnAddress;
    cfg_data       = '0;
    cur_addr       = AddressReset;
    cur_limit      = int'(TimeoutReset);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks, a stray byte, empty payload, short payload, oversize lengths
    send_beat(ReqTick, 8'hFF);
    send_beat(ReqTick, 8'h00);
    send_beat(ReqByte, 8'hA5);
    send_frame(8'hFF, 16'd0, FullFrame);
    send_frame(8'h00, 16'd2, FullFrame);
    send_frame(8'h3C, 16'h0101, FullFrame);
    send_frame(8'h81, 16'hFFFF, FullFrame);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      addr_sel = 8'($urandom_range(255));
      calm     = 1'b0;
      case (p)
        0: begin addr_sel = 8'hFF; tmo_sel = 16'd1; end
        1: begin addr_sel = 8'h5A; tmo_sel = 16'd3; end
        2: tmo_sel = 16'd0;
        3: begin tmo_sel = 16'hFFFF; calm = 1'b1; end
        4: begin addr_sel = 8'h00; tmo_sel = TimeoutReset; end
        default: tmo_sel = TickW'($urandom_range(2, 8));
      endcase
      configure(addr_sel, tmo_sel);
      phase_start = beats_sent;
      frames      = 0;
      if (p == 3) send_frame(8'($urandom_range(255)), MaxPayload, FullFrame);
      while (beats_sent - phase_start < 270) begin
        if (p == 1 && frames == 5) drain_results();
        random_frame();
        frames++;
      end
    end
    calm = 1'b0;
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
